// ===== src/assert_macros.svh =====
// Assertion macros used by the timer bank top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an implication property on the rising clock edge, off during reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds on the rising clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== src/tmrb_pkg.sv =====
// Types, constants and helpers of the timer slot bank.
`default_nettype none
package tmrb_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MASK_W  = (SLOTS > 16) ? SLOTS : 16;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_RUN       = 2'd0,
    FUNC_START_ONE = 2'd1,
    FUNC_START_REP = 2'd2,
    FUNC_STOP      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ACK     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SUM
  } bk_state_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    func_e              op;
    logic [3:0]         slot;
    logic [SLOT_W-1:0]  slot_idx;
    logic               in_range;
    logic [31:0]        interval;
    logic [31:0]        now;
  } cmd_t;

  // A wrap-safe difference is positive when nonzero with a clear sign bit
  function automatic logic is_positive(input logic [31:0] d);
    return (d != 32'd0) && !d[31];
  endfunction

endpackage
`default_nettype wire

// ===== src/multi_slot_software_timer_bank_top.sv =====
// Top level of the timer slot bank: front queue, back engine and checks.
//
// Input beats on the s_axis channel carry a command in tuser (run scan,
// start one-shot, start repeating, stop) and slot, interval and current time
// in tdata. The front queues up to two commands, so a beat is taken while
// the back is still busy. Results leave on m_axis from one output register.
// A start or stop gives one acknowledge beat, passed through the queue and
// the output register. A run latches the time and scans one slot per cycle
// over all slots while no due slot waits on a full output register, emitting
// an expiry beat for each due slot, then a summary beat with tlast. The back
// takes no new command until that summary is sent, and takes one start or
// stop per cycle while the receiver accepts every beat.
// A stalled receiver holds the output register; the scan then waits on the
// next due slot and the queue fills, after which s_axis_tready drops.
// Reset disarms every slot, clears the latched time to zero and empties the
// queue; slot tables hold no value until a start writes them.
`default_nettype none
`include "assert_macros.svh"
module multi_slot_software_timer_bank_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] func
  input  wire logic [1:0]  s_axis_tuser,
  // [3:0] slot, [35:4] interval, [67:36] now_ticks, [71:68] zero
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] kind
  output logic [1:0]       m_axis_tuser,
  // [3:0] slot_index, [35:4] ticks_to_next, [51:36] active_mask, [55:52] zero
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  tmrb_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_pop;
  logic [3:0]     out_slot;
  logic [31:0]    out_ticks;
  logic [15:0]    out_mask;

  tmrb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_func_i     (s_axis_tuser),
    .in_slot_i     (s_axis_tdata[3:0]),
    .in_interval_i (s_axis_tdata[35:4]),
    .in_now_i      (s_axis_tdata[67:36]),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  tmrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_slot_o  (out_slot),
    .out_ticks_o (out_ticks),
    .out_mask_o  (out_mask),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'd0, out_mask, out_ticks, out_slot};

  // Only expiry beats leave tlast low
  `ASSERT_AT(a_last_kind, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != tmrb_pkg::KIND_EXPIRED)), "tlast does not match result kind")
  // Ticks field is zero outside summary beats
  `ASSERT_AT(a_ticks_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != tmrb_pkg::KIND_SUMMARY) |-> (m_axis_tdata[35:4] == 32'd0), "ticks set outside summary")
  // The back never pops an empty queue
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, cmd_pop && !cmd_valid, "command popped from empty queue")

endmodule
`default_nettype wire

// ===== src/tmrb_front.sv =====
// Front end: accepts beats, classifies them and queues commands for the back.
`default_nettype none
module tmrb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    in_func_i,
  input  wire logic [3:0]    in_slot_i,
  input  wire logic [31:0]   in_interval_i,
  input  wire logic [31:0]   in_now_i,
  output logic               cmd_valid_o,
  output tmrb_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);

  tmrb_pkg::cmd_t                  q_mem [tmrb_pkg::QDEPTH];
  logic [tmrb_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tmrb_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tmrb_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  tmrb_pkg::cmd_t                  cls;
  logic                            push, pop;

  // Classify the incoming beat
  always_comb begin
    cls.op       = tmrb_pkg::func_e'(in_func_i);
    cls.slot     = in_slot_i;
    cls.slot_idx = tmrb_pkg::SLOT_W'(in_slot_i);
    cls.in_range = (32'(in_slot_i) < 32'(tmrb_pkg::SLOTS));
    cls.interval = in_interval_i;
    cls.now      = in_now_i;
  end

  assign in_ready_o  = (cnt_q != tmrb_pkg::QCNT_W'(tmrb_pkg::QDEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tmrb_pkg::QPTR_W'(tmrb_pkg::QDEPTH - 1)) ?
                 '0 : tmrb_pkg::QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tmrb_pkg::QPTR_W'(tmrb_pkg::QDEPTH - 1)) ?
                 '0 : tmrb_pkg::QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = tmrb_pkg::QCNT_W'(cnt_q + 1'b1);
    end else if (!push && pop) begin
      cnt_d = tmrb_pkg::QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the queued command
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== src/tmrb_back.sv =====
// Back end: executes commands, scans slots and drives the result register.
`default_nettype none
module tmrb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire tmrb_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic [3:0]         out_slot_o,
  output logic [31:0]        out_ticks_o,
  output logic [15:0]        out_mask_o,
  output logic               out_last_o
);

  localparam logic [tmrb_pkg::SLOT_W-1:0] LastIdx = tmrb_pkg::SLOT_W'(tmrb_pkg::SLOTS - 1);

  tmrb_pkg::bk_state_e          state_q, state_d;
  logic [tmrb_pkg::SLOTS-1:0]   armed_q, armed_d;
  logic [tmrb_pkg::SLOTS-1:0]   periodic_q;
  logic [31:0]                  expiry_q [tmrb_pkg::SLOTS];
  logic [31:0]                  period_q [tmrb_pkg::SLOTS];
  logic [31:0]                  now_q, now_d;
  logic [31:0]                  best_q, best_d;
  logic [tmrb_pkg::SLOT_W-1:0]  idx_q, idx_d;

  logic                         out_valid_q;
  logic [1:0]                   out_kind_q;
  logic [3:0]                   out_slot_q;
  logic [31:0]                  out_ticks_q;
  logic [15:0]                  out_mask_q;
  logic                         out_last_q;

  logic                         out_free, advance, due;
  logic [31:0]                  exp_rd, per_rd, d_cur, reload, d_rel;
  logic                         emit, emit_last;
  tmrb_pkg::kind_e              emit_kind;
  logic [3:0]                   emit_slot;
  logic [31:0]                  emit_ticks;
  logic [tmrb_pkg::MASK_W-1:0]  mask_wide;
  logic                         we_exp, we_cfg;
  logic [tmrb_pkg::SLOT_W-1:0]  wr_idx;
  logic [31:0]                  exp_wdata;

  // Read the slot under scan and form its differences
  assign exp_rd   = expiry_q[idx_q];
  assign per_rd   = period_q[idx_q];
  assign d_cur    = exp_rd - now_q;
  assign reload   = exp_rd + per_rd;
  assign d_rel    = reload - now_q;
  assign due      = armed_q[idx_q] && !tmrb_pkg::is_positive(d_cur);
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = !due || out_free;
  assign mask_wide = tmrb_pkg::MASK_W'(armed_d);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tmrb_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.op == tmrb_pkg::FUNC_RUN) begin
          state_d = tmrb_pkg::BK_SCAN;
        end
      end
      tmrb_pkg::BK_SCAN: begin
        if (advance && idx_q == LastIdx) begin
          state_d = tmrb_pkg::BK_SUM;
        end
      end
      tmrb_pkg::BK_SUM: begin
        if (out_free) begin
          state_d = tmrb_pkg::BK_IDLE;
        end
      end
      default: state_d = tmrb_pkg::BK_IDLE;
    endcase
  end

  // Command execution, slot updates and result selection
  always_comb begin
    cmd_pop_o  = 1'b0;
    armed_d    = armed_q;
    now_d      = now_q;
    best_d     = best_q;
    idx_d      = idx_q;
    emit       = 1'b0;
    emit_kind  = tmrb_pkg::KIND_ACK;
    emit_slot  = 4'd0;
    emit_ticks = 32'd0;
    emit_last  = 1'b0;
    we_exp     = 1'b0;
    we_cfg     = 1'b0;
    wr_idx     = idx_q;
    exp_wdata  = reload;
    case (state_q)
      tmrb_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == tmrb_pkg::FUNC_RUN) begin
            cmd_pop_o = 1'b1;
            now_d     = cmd_i.now;
            best_d    = tmrb_pkg::ALL_ONES_32;
            idx_d     = '0;
          end else if (out_free) begin
            cmd_pop_o = 1'b1;
            emit      = 1'b1;
            emit_kind = tmrb_pkg::KIND_ACK;
            emit_slot = cmd_i.slot;
            emit_last = 1'b1;
            wr_idx    = cmd_i.slot_idx;
            exp_wdata = now_q + cmd_i.interval;
            if (cmd_i.in_range) begin
              if (cmd_i.op == tmrb_pkg::FUNC_STOP) begin
                armed_d[cmd_i.slot_idx] = 1'b0;
              end else begin
                armed_d[cmd_i.slot_idx] = 1'b1;
                we_exp = 1'b1;
                we_cfg = 1'b1;
              end
            end
          end
        end
      end
      tmrb_pkg::BK_SCAN: begin
        if (advance) begin
          if (idx_q != LastIdx) begin
            idx_d = tmrb_pkg::SLOT_W'(idx_q + 1'b1);
          end
          if (armed_q[idx_q] && tmrb_pkg::is_positive(d_cur) && d_cur < best_q) begin
            best_d = d_cur;
          end
          if (due) begin
            emit      = 1'b1;
            emit_kind = tmrb_pkg::KIND_EXPIRED;
            emit_slot = 4'(idx_q);
            if (periodic_q[idx_q]) begin
              we_exp = 1'b1;
              if (tmrb_pkg::is_positive(d_rel) && d_rel < best_q) begin
                best_d = d_rel;
              end
            end else begin
              armed_d[idx_q] = 1'b0;
            end
          end
        end
      end
      tmrb_pkg::BK_SUM: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = tmrb_pkg::KIND_SUMMARY;
          emit_ticks = best_q;
          emit_last  = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmrb_pkg::BK_IDLE;
      armed_q     <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
      now_q   <= now_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan registers and result payload
  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    idx_q  <= idx_d;
    if (emit) begin
      out_kind_q  <= emit_kind;
      out_slot_q  <= emit_slot;
      out_ticks_q <= emit_ticks;
      out_mask_q  <= mask_wide[15:0];
      out_last_q  <= emit_last;
    end
  end

  // Slot tables
  always_ff @(posedge clk_i) begin
    if (we_exp) begin
      expiry_q[wr_idx] <= exp_wdata;
    end
    if (we_cfg) begin
      period_q[wr_idx]   <= cmd_i.interval;
      periodic_q[wr_idx] <= (cmd_i.op == tmrb_pkg::FUNC_START_REP);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_slot_o  = out_slot_q;
  assign out_ticks_o = out_ticks_q;
  assign out_mask_o  = out_mask_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire
